// File: sv/tlik_pkg.sv
`default_nettype none
package tlik_pkg;

  localparam int LINK_LENGTH_MM_DEF = 300;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int COORD_W    = 16;
  localparam int R2CFG_W    = 23;
  localparam int POS_W      = 17;
  localparam int R2_W       = 34;
  localparam int R2Q_W      = 28;
  localparam int SQ_IN_W    = 60;
  localparam int ROOT_W     = 30;
  localparam int MAG_W      = 14;
  localparam int PROD_W     = ROOT_W + MAG_W;
  localparam int VEC_W      = 33;
  localparam int ANG_W      = 35;
  localparam int CORDIC_ITERS = 31;

  localparam logic signed [COORD_W:0] X_MAX_Q4 = 17'sd9600;
  localparam logic signed [COORD_W:0] Y_MIN_Q4 = 17'sd640;
  localparam logic signed [COORD_W:0] Y_MAX_Q4 = 17'sd9600;

  localparam logic [R2CFG_W-1:0] MIN_R2_RST = 23'd2500;
  localparam logic [R2CFG_W-1:0] MAX_R2_RST = 23'd360000;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 35'sd3373259426;

  // radians Q30 -> counts: * 34377468 / (10000 * 2^30)
  localparam logic [25:0] RC_MUL      = 26'd34377468;
  localparam int          RC_SPLIT    = 17;
  localparam int          RC_FRAC     = 30;
  localparam int          RC_N_W      = 28;
  localparam logic [27:0] RC_RECIP    = 28'd219902326;
  localparam int          RC_RECIP_SH = 41;
  localparam int          RC_Q_W      = 15;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RADIUS,
    ST_X,
    ST_Y
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_X,
    REG_BASE_Y,
    REG_SHOULDER_OFS,
    REG_ELBOW_OFS,
    REG_MIN_R2,
    REG_MAX_R2
  } reg_idx_t;

  typedef logic signed [COORD_W:0] coord_t;

  typedef struct packed {
    status_t status;
    coord_t  x;
  } sq_tag_x_t;

  typedef struct packed {
    status_t status;
    coord_t  x;
    logic    y_neg;
  } dv_tag_x_t;

  typedef struct packed {
    coord_t y;
    logic   x_neg;
  } dv_tag_y_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'd843314857;
      1:  v = 30'd497837829;
      2:  v = 30'd263043837;
      3:  v = 30'd133525159;
      4:  v = 30'd67021687;
      5:  v = 30'd33543516;
      6:  v = 30'd16775851;
      7:  v = 30'd8388437;
      8:  v = 30'd4194283;
      9:  v = 30'd2097149;
      default: v = (i < 30) ? 30'(30'd1 << (30 - i)) : 30'd1;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: sv/two_link_arm_inverse_kinematics_unit.sv
// Channel   Signals                                          Dir  Handshake
// request   start, target_x, target_y                        in   start & !busy
// result    done, status, shoulder_position, elbow_position  out  done, one cycle
// config    cfg_valid, cfg_index, cfg_data                   in   cfg_valid & cfg_ready
//
// One request per cycle; busy stays low, cfg_ready stays high.
// The pipeline holds two 30-stage square roots, two 30-stage dividers,
// two 32-stage CORDIC arrays and a 4-stage angle-to-count scaler.
// rst is synchronous, clears the pipeline valids and loads the config registers' reset values.
// The receiver cannot stall; done is raised for exactly one cycle per request.
`default_nettype none
module two_link_arm_inverse_kinematics_unit
  import tlik_pkg::*;
#(
  parameter int LINK_LENGTH_MM = LINK_LENGTH_MM_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] target_x,
  input  logic signed [COORD_W-1:0] target_y,
  output logic                      done,
  output logic [1:0]                status,
  output logic signed [POS_W-1:0]   shoulder_position,
  output logic signed [POS_W-1:0]   elbow_position,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam logic [R2_W-1:0] L2K = R2_W'(LINK_LENGTH_MM * LINK_LENGTH_MM * 1024);
  localparam int LATENCY = 3 + ROOT_W + 1 + ROOT_W + 1 + (CORDIC_ITERS + 1) + 4 + 1;

  logic signed [COORD_W-1:0] box;
  logic signed [COORD_W-1:0] boy;
  logic signed [COORD_W-1:0] sho_ofs;
  logic signed [COORD_W-1:0] elb_ofs;
  logic [R2CFG_W-1:0]        min_r2;
  logic [R2CFG_W-1:0]        max_r2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box     <= '0;
      boy     <= '0;
      sho_ofs <= '0;
      elb_ofs <= '0;
      min_r2  <= MIN_R2_RST;
      max_r2  <= MAX_R2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE_X:       box     <= cfg_data[COORD_W-1:0];
        REG_BASE_Y:       boy     <= cfg_data[COORD_W-1:0];
        REG_SHOULDER_OFS: sho_ofs <= cfg_data[COORD_W-1:0];
        REG_ELBOW_OFS:    elb_ofs <= cfg_data[COORD_W-1:0];
        REG_MIN_R2:       min_r2  <= cfg_data;
        REG_MAX_R2:       max_r2  <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage A: offset removal
  logic   a_vld;
  coord_t a_x;
  coord_t a_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_x <= (COORD_W+1)'(target_x) - (COORD_W+1)'(box);
    a_y <= (COORD_W+1)'(target_y) - (COORD_W+1)'(boy);
  end

  // stage B: squared reach
  logic            b_vld;
  coord_t          b_x;
  coord_t          b_y;
  logic [R2_W-1:0] b_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_x  <= a_x;
    b_y  <= a_y;
    b_r2 <= R2_W'(R2_W'(a_x) * R2_W'(a_x)) + R2_W'(R2_W'(a_y) * R2_W'(a_y));
  end

  // stage C: range checks and d^2
  logic              c_vld;
  coord_t            c_x;
  coord_t            c_y;
  status_t           c_status;
  logic [ROOT_W-1:0] c_d2;
  logic [R2Q_W-1:0]  c_r2;
  status_t           c_status_next;

  always_comb begin
    if (b_r2 < R2_W'({min_r2, 8'b0}) || b_r2 > R2_W'({max_r2, 8'b0})) begin
      c_status_next = ST_RADIUS;
    end else if (b_x < -X_MAX_Q4 || b_x > X_MAX_Q4) begin
      c_status_next = ST_X;
    end else if (b_y < Y_MIN_Q4 || b_y > Y_MAX_Q4) begin
      c_status_next = ST_Y;
    end else begin
      c_status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_x      <= b_x;
    c_y      <= b_y;
    c_status <= c_status_next;
    c_r2     <= b_r2[R2Q_W-1:0];
    if (b_r2 >= L2K) begin
      c_d2 <= '0;
    end else begin
      c_d2 <= ROOT_W'(L2K - b_r2);
    end
  end

  // square roots: dq = sqrt(d2 << 30), rq = sqrt(r2 << 32)
  logic              sq_vld_d;
  logic              sq_vld_r;
  logic [ROOT_W-1:0] sq_dq;
  logic [ROOT_W-1:0] sq_rq;
  sq_tag_x_t         sq_tag_x;
  coord_t            sq_y;

  tlik_isqrt #(.TAG_W($bits(sq_tag_x_t))) u_sqrt_d (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_vld),
    .in_rad    ({c_d2, 30'b0}),
    .in_tag    (sq_tag_x_t'{status: c_status, x: c_x}),
    .out_valid (sq_vld_d),
    .out_root  (sq_dq),
    .out_tag   (sq_tag_x)
  );

  tlik_isqrt #(.TAG_W($bits(coord_t))) u_sqrt_r (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_vld),
    .in_rad    ({c_r2, 32'b0}),
    .in_tag    (c_y),
    .out_valid (sq_vld_r),
    .out_root  (sq_rq),
    .out_tag   (sq_y)
  );

  // stage D: dq * |y|, dq * |x|
  logic              d_vld;
  logic [PROD_W-1:0] d_ny;
  logic [PROD_W-1:0] d_nx;
  logic [ROOT_W-1:0] d_rq;
  dv_tag_x_t         d_tag_x;
  dv_tag_y_t         d_tag_y;
  logic [COORD_W:0]  abs_x;
  logic [COORD_W:0]  abs_y;

  assign abs_x = (sq_tag_x.x < 0) ? (COORD_W+1)'(-sq_tag_x.x) : (COORD_W+1)'(sq_tag_x.x);
  assign abs_y = (sq_y < 0) ? (COORD_W+1)'(-sq_y) : (COORD_W+1)'(sq_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= sq_vld_d && sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d_ny    <= PROD_W'(sq_dq * abs_y[MAG_W-1:0]);
    d_nx    <= PROD_W'(sq_dq * abs_x[MAG_W-1:0]);
    d_rq    <= sq_rq;
    d_tag_x <= '{status: sq_tag_x.status, x: sq_tag_x.x, y_neg: sq_y < 0};
    d_tag_y <= '{y: sq_y, x_neg: sq_tag_x.x < 0};
  end

  // dividers: q = dq * |v| * 65536 / rq
  logic              dv_vld_y;
  logic              dv_vld_x;
  logic [ROOT_W-1:0] qy;
  logic [ROOT_W-1:0] qx;
  dv_tag_x_t         dv_tag_x;
  dv_tag_y_t         dv_tag_y;

  tlik_div #(.TAG_W($bits(dv_tag_x_t))) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_vld),
    .in_num    ({d_ny, 16'b0}),
    .in_den    (d_rq),
    .in_tag    (d_tag_x),
    .out_valid (dv_vld_y),
    .out_quo   (qy),
    .out_tag   (dv_tag_x)
  );

  tlik_div #(.TAG_W($bits(dv_tag_y_t))) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_vld),
    .in_num    ({d_nx, 16'b0}),
    .in_den    (d_rq),
    .in_tag    (d_tag_y),
    .out_valid (dv_vld_x),
    .out_quo   (qx),
    .out_tag   (dv_tag_y)
  );

  // stage E: elbow point and elbow-to-target vector
  logic                    e_vld;
  status_t                 e_status;
  logic signed [VEC_W-1:0] e_mx;
  logic signed [VEC_W-1:0] e_my;
  logic signed [VEC_W-1:0] e_vx;
  logic signed [VEC_W-1:0] e_vy;
  logic signed [VEC_W-1:0] qy_s;
  logic signed [VEC_W-1:0] qx_s;
  logic signed [VEC_W-1:0] hx;
  logic signed [VEC_W-1:0] hy;

  assign qy_s = dv_tag_x.y_neg ? -signed'(VEC_W'(qy)) : signed'(VEC_W'(qy));
  assign qx_s = dv_tag_y.x_neg ? -signed'(VEC_W'(qx)) : signed'(VEC_W'(qx));
  assign hx   = VEC_W'(dv_tag_x.x) <<< 15;
  assign hy   = VEC_W'(dv_tag_y.y) <<< 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= dv_vld_y && dv_vld_x;
    end
  end

  always_ff @(posedge clk) begin
    e_status <= dv_tag_x.status;
    e_mx     <= hx + qy_s;
    e_my     <= hy - qx_s;
    e_vx     <= hx - qy_s;
    e_vy     <= hy + qx_s;
  end

  // angles
  logic                    cr_vld_s;
  logic                    cr_vld_e;
  logic signed [ANG_W-1:0] ang_s;
  logic signed [ANG_W-1:0] ang_e;
  logic                    cr_st0;
  logic                    cr_st1;

  tlik_cordic #(.TAG_W(1)) u_cordic_s (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_vld),
    .in_x      (e_mx),
    .in_y      (e_my),
    .in_tag    (e_status[0]),
    .out_valid (cr_vld_s),
    .out_angle (ang_s),
    .out_tag   (cr_st0)
  );

  tlik_cordic #(.TAG_W(1)) u_cordic_e (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (e_vld),
    .in_x      (e_vx),
    .in_y      (e_vy),
    .in_tag    (e_status[1]),
    .out_valid (cr_vld_e),
    .out_angle (ang_e),
    .out_tag   (cr_st1)
  );

  // motor counts
  logic                    k_vld_s;
  logic                    k_vld_e;
  logic signed [POS_W-1:0] pos_s;
  logic signed [POS_W-1:0] pos_e;
  logic                    k_st0;
  logic                    k_st1;
  status_t                 k_status;

  tlik_count #(.TAG_W(1)) u_count_s (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cr_vld_s),
    .in_angle  (ang_s),
    .in_offset (sho_ofs),
    .in_tag    (cr_st0),
    .out_valid (k_vld_s),
    .out_pos   (pos_s),
    .out_tag   (k_st0)
  );

  tlik_count #(.TAG_W(1)) u_count_e (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cr_vld_e),
    .in_angle  (ang_e),
    .in_offset (elb_ofs),
    .in_tag    (cr_st1),
    .out_valid (k_vld_e),
    .out_pos   (pos_e),
    .out_tag   (k_st1)
  );

  assign k_status = status_t'({k_st1, k_st0});

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= k_vld_s && k_vld_e;
    end
  end

  always_ff @(posedge clk) begin
    status <= k_status;
    if (k_status == ST_OK) begin
      shoulder_position <= pos_s;
      elbow_position    <= pos_e;
    end else begin
      shoulder_position <= '0;
      elbow_position    <= '0;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("request did not complete after pipeline latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without matching request");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> shoulder_position == '0 && elbow_position == '0)
    else $error("rejected target produced nonzero positions");
`endif

endmodule
`default_nettype wire

// File: sv/tlik_isqrt.sv
`default_nettype none
module tlik_isqrt
  import tlik_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [SQ_IN_W-1:0]  in_rad,
  input  logic [TAG_W-1:0]    in_tag,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_root,
  output logic [TAG_W-1:0]    out_tag
);

  localparam int REM_W = ROOT_W + 2;

  logic                vld  [ROOT_W];
  logic [SQ_IN_W-1:0]  rad  [ROOT_W];
  logic [ROOT_W-1:0]   root [ROOT_W];
  logic [REM_W-1:0]    rem  [ROOT_W];
  logic [TAG_W-1:0]    tag  [ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic               s_vld;
    logic [SQ_IN_W-1:0] s_rad;
    logic [ROOT_W-1:0]  s_root;
    logic [REM_W-1:0]   s_rem;
    logic [TAG_W-1:0]   s_tag;
    logic [REM_W+1:0]   acc;
    logic [REM_W+1:0]   trial;
    logic               fits;

    if (s == 0) begin : g_first
      assign s_vld  = in_valid;
      assign s_rad  = in_rad;
      assign s_root = '0;
      assign s_rem  = '0;
      assign s_tag  = in_tag;
    end else begin : g_next
      assign s_vld  = vld[s-1];
      assign s_rad  = rad[s-1];
      assign s_root = root[s-1];
      assign s_rem  = rem[s-1];
      assign s_tag  = tag[s-1];
    end

    assign acc   = {s_rem, s_rad[SQ_IN_W-1 -: 2]};
    assign trial = {2'b00, s_root, 2'b01};
    assign fits  = acc >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      rad[s] <= s_rad << 2;
      tag[s] <= s_tag;
      if (fits) begin
        rem[s]  <= REM_W'(acc - trial);
        root[s] <= {s_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem[s]  <= REM_W'(acc);
        root[s] <= {s_root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_tag   = tag[ROOT_W-1];

endmodule
`default_nettype wire

// File: sv/tlik_div.sv
`default_nettype none
module tlik_div
  import tlik_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [SQ_IN_W-1:0] in_num,
  input  logic [ROOT_W-1:0]  in_den,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_valid,
  output logic [ROOT_W-1:0]  out_quo,
  output logic [TAG_W-1:0]   out_tag
);

  // quotient known to fit ROOT_W bits
  localparam int Q_W = ROOT_W;

  logic              vld [Q_W];
  logic [ROOT_W-1:0] den [Q_W];
  logic [Q_W-1:0]    low [Q_W];
  logic [Q_W-1:0]    quo [Q_W];
  logic [ROOT_W-1:0] rem [Q_W];
  logic [TAG_W-1:0]  tag [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic              s_vld;
    logic [ROOT_W-1:0] s_den;
    logic [Q_W-1:0]    s_low;
    logic [Q_W-1:0]    s_quo;
    logic [ROOT_W-1:0] s_rem;
    logic [TAG_W-1:0]  s_tag;
    logic [ROOT_W:0]   acc;
    logic              fits;

    if (s == 0) begin : g_first
      assign s_vld = in_valid;
      assign s_den = in_den;
      assign s_low = in_num[Q_W-1:0];
      assign s_quo = '0;
      assign s_rem = ROOT_W'(in_num[SQ_IN_W-1:Q_W]);
      assign s_tag = in_tag;
    end else begin : g_next
      assign s_vld = vld[s-1];
      assign s_den = den[s-1];
      assign s_low = low[s-1];
      assign s_quo = quo[s-1];
      assign s_rem = rem[s-1];
      assign s_tag = tag[s-1];
    end

    assign acc  = {s_rem, s_low[Q_W-1]};
    assign fits = acc >= {1'b0, s_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      den[s] <= s_den;
      low[s] <= s_low << 1;
      tag[s] <= s_tag;
      quo[s] <= {s_quo[Q_W-2:0], fits};
      if (fits) begin
        rem[s] <= ROOT_W'(acc - {1'b0, s_den});
      end else begin
        rem[s] <= ROOT_W'(acc);
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign out_quo   = quo[Q_W-1];
  assign out_tag   = tag[Q_W-1];

endmodule
`default_nettype wire

// File: sv/tlik_cordic.sv
`default_nettype none
module tlik_cordic
  import tlik_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [VEC_W-1:0] in_x,
  input  logic signed [VEC_W-1:0] in_y,
  input  logic [TAG_W-1:0]        in_tag,
  output logic                    out_valid,
  output logic signed [ANG_W-1:0] out_angle,
  output logic [TAG_W-1:0]        out_tag
);

  localparam int IW = VEC_W + 3;

  logic                    p_vld;
  logic signed [IW-1:0]    p_x;
  logic signed [IW-1:0]    p_y;
  logic signed [ANG_W-1:0] p_z;
  logic [TAG_W-1:0]        p_tag;

  logic                    vld [CORDIC_ITERS];
  logic signed [IW-1:0]    cx  [CORDIC_ITERS];
  logic signed [IW-1:0]    cy  [CORDIC_ITERS];
  logic signed [ANG_W-1:0] cz  [CORDIC_ITERS];
  logic [TAG_W-1:0]        tag [CORDIC_ITERS];

  // fold left half-plane into the right one
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    p_tag <= in_tag;
    if (in_x < 0) begin
      p_x <= -IW'(in_x);
      p_y <= -IW'(in_y);
      p_z <= (in_y >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      p_x <= IW'(in_x);
      p_y <= IW'(in_y);
      p_z <= '0;
    end
  end

  for (genvar s = 0; s < CORDIC_ITERS; s++) begin : g_stage
    logic                    s_vld;
    logic signed [IW-1:0]    s_x;
    logic signed [IW-1:0]    s_y;
    logic signed [ANG_W-1:0] s_z;
    logic [TAG_W-1:0]        s_tag;
    logic signed [IW-1:0]    dx;
    logic signed [IW-1:0]    dy;
    logic signed [ANG_W-1:0] ang;

    if (s == 0) begin : g_first
      assign s_vld = p_vld;
      assign s_x   = p_x;
      assign s_y   = p_y;
      assign s_z   = p_z;
      assign s_tag = p_tag;
    end else begin : g_next
      assign s_vld = vld[s-1];
      assign s_x   = cx[s-1];
      assign s_y   = cy[s-1];
      assign s_z   = cz[s-1];
      assign s_tag = tag[s-1];
    end

    assign dx  = s_y >>> s;
    assign dy  = s_x >>> s;
    assign ang = signed'(ANG_W'(atan_q30(s)));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else begin
        vld[s] <= s_vld;
      end
    end

    always_ff @(posedge clk) begin
      tag[s] <= s_tag;
      if (s_y > 0) begin
        cx[s] <= s_x + dx;
        cy[s] <= s_y - dy;
        cz[s] <= s_z + ang;
      end else begin
        cx[s] <= s_x - dx;
        cy[s] <= s_y + dy;
        cz[s] <= s_z - ang;
      end
    end
  end

  assign out_valid = vld[CORDIC_ITERS-1];
  assign out_angle = cz[CORDIC_ITERS-1];
  assign out_tag   = tag[CORDIC_ITERS-1];

endmodule
`default_nettype wire

// File: sv/tlik_count.sv
`default_nettype none
module tlik_count
  import tlik_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic signed [ANG_W-1:0]   in_angle,
  input  logic signed [COORD_W-1:0] in_offset,
  input  logic [TAG_W-1:0]          in_tag,
  output logic                      out_valid,
  output logic signed [POS_W-1:0]   out_pos,
  output logic [TAG_W-1:0]          out_tag
);

  localparam int AMAG_W = ANG_W - 1;
  localparam int HI_W   = AMAG_W - RC_SPLIT;
  localparam int PH_W   = HI_W + 26;
  localparam int PL_W   = RC_SPLIT + 26;
  localparam int SUM_W  = PH_W + RC_SPLIT + 1;
  localparam int M_W    = RC_N_W + 28;

  logic [3:0]             vld;
  logic [TAG_W-1:0]       tag [4];
  logic [3:0]             neg;
  logic [PH_W-1:0]        ph;
  logic [PL_W-1:0]        pl;
  logic [RC_N_W-1:0]      n;
  logic [M_W-1:0]         m;

  logic [ANG_W-1:0]       mag;
  logic [SUM_W-1:0]       psum;
  logic [POS_W-1:0]       q_ext;

  assign mag   = (in_angle < 0) ? ANG_W'(-in_angle) : ANG_W'(in_angle);
  assign psum  = SUM_W'({ph, RC_SPLIT'(0)}) + SUM_W'(pl);
  assign q_ext = POS_W'(m[RC_RECIP_SH +: RC_Q_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag[0] <= in_tag;
    tag[1] <= tag[0];
    tag[2] <= tag[1];
    tag[3] <= tag[2];
    neg    <= {neg[2:0], in_angle < 0};
    ph     <= PH_W'(mag[AMAG_W-1:RC_SPLIT] * RC_MUL);
    pl     <= PL_W'(mag[RC_SPLIT-1:0] * RC_MUL);
    n      <= psum[RC_FRAC +: RC_N_W];
    m      <= M_W'(n * RC_RECIP);
    out_pos <= POS_W'(in_offset) + (neg[2] ? -signed'(q_ext) : signed'(q_ext));
  end

  assign out_valid = vld[3];
  assign out_tag   = tag[3];

endmodule
`default_nettype wire
